// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define TLI_ASSERT_IMP(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication, held off while reset is asserted.
`define TLI_ASSERT_NXT(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

// ===== src/tli_pkg.sv =====
`default_nettype none

package tli_pkg;

	localparam int unsigned PC_W = 7;
	localparam logic [PC_W-1:0] PC_RESET = 7'd2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic REG_POINT_COUNT = 1'b0;

	// correction term: |dy| * |d2| / (2 |dx|), quotient limited to QUO_BITS
	localparam int unsigned DY_W     = 33;
	localparam int unsigned D2_W     = 34;
	localparam int unsigned DV_W     = 34;
	localparam int unsigned MUL_LO_W = 17;
	localparam int unsigned PP_W     = DY_W + MUL_LO_W;
	localparam int unsigned PROD_W   = DY_W + D2_W;
	localparam int unsigned QUO_BITS = 40;
	localparam int unsigned DCNT_W   = 6;
	localparam int unsigned SUM_W    = QUO_BITS + 2;

	typedef struct packed {
		logic               cmd;
		logic [5:0]         entry_index;
		logic signed [31:0] entry_position;
		logic signed [31:0] entry_value;
		logic signed [31:0] query_position;
	} req_t;

	typedef struct packed {
		logic signed [31:0] interpolated_value;
		logic               zero_width_segment;
		logic               saturated;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_LO_RD,
		ST_LO_LATCH,
		ST_MUL0,
		ST_MUL1,
		ST_DIV_INIT,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic mem_wr;
		logic query_ld;
		logic mem_rd;
		logic hi_ld;
		logic lo_ld;
		logic mul_lo;
		logic mul_hi;
		logic div_init;
		logic div_step;
		logic res_ld;
	} dp_cmd_t;

	typedef struct packed {
		logic x_lt_q;
		logic zero_dx;
		logic res_busy;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== src/tli_ctrl.sv =====
`default_nettype none

module tli_ctrl #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	input  wire logic                              req_cmd,
	output logic                                   req_stall,
	input  wire logic [tli_pkg::PC_W-1:0]          point_count,
	input  wire tli_pkg::dp_stat_t                 stat,
	output tli_pkg::dp_cmd_t                       cmd,
	output logic [$clog2(TABLE_DEPTH)-1:0]         rd_addr
);
	import tli_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = ((AW > PC_W) ? AW : PC_W) + 1;

	state_t              state_q, state_d;
	logic [AW-1:0]       idx_q, idx_d;
	logic [DCNT_W-1:0]   cnt_q, cnt_d;
	logic [CW-1:0]       pc_x, n_eff;
	logic                last_seg;

	// clamp point count to [2, TABLE_DEPTH]
	always_comb begin
		pc_x = CW'(point_count);
		priority if (pc_x < CW'(2)) begin
			n_eff = CW'(2);
		end else if (pc_x > CW'(TABLE_DEPTH)) begin
			n_eff = CW'(TABLE_DEPTH);
		end else begin
			n_eff = pc_x;
		end
	end

	assign last_seg = (CW'(idx_q) + CW'(2)) >= n_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		cnt_d     = cnt_q;
		cmd       = '0;
		rd_addr   = idx_q;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					if (req_cmd == CMD_LOAD) begin
						cmd.mem_wr = 1'b1;
					end else begin
						cmd.query_ld = 1'b1;
						idx_d        = AW'(1);
						state_d      = ST_SRCH_RD;
					end
				end
			end
			ST_SRCH_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_SRCH_CMP;
			end
			ST_SRCH_CMP: begin
				if (stat.x_lt_q && !last_seg) begin
					idx_d   = idx_q + AW'(1);
					state_d = ST_SRCH_RD;
				end else begin
					cmd.hi_ld = 1'b1;
					state_d   = ST_LO_RD;
				end
			end
			ST_LO_RD: begin
				cmd.mem_rd = 1'b1;
				rd_addr    = idx_q - AW'(1);
				state_d    = ST_LO_LATCH;
			end
			ST_LO_LATCH: begin
				cmd.lo_ld = 1'b1;
				state_d   = ST_MUL0;
			end
			ST_MUL0: begin
				if (stat.zero_dx) begin
					state_d = ST_DONE;
				end else begin
					cmd.mul_lo = 1'b1;
					state_d    = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + DCNT_W'(1);
				if (cnt_q == DCNT_W'(QUO_BITS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold until the result register can take the answer
				if (!stat.res_busy) begin
					cmd.res_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/tli_dp.sv =====
`default_nettype none

module tli_dp #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tli_pkg::req_t                     req,
	input  wire tli_pkg::dp_cmd_t                  cmd,
	input  wire logic [$clog2(TABLE_DEPTH)-1:0]    rd_addr,
	output tli_pkg::dp_stat_t                      stat,
	output logic                                   res_valid,
	input  wire logic                              res_stall,
	output tli_pkg::res_t                          res
);
	import tli_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = ((AW > PC_W) ? AW : PC_W) + 1;

	logic [31:0] abs_mem [TABLE_DEPTH];
	logic [31:0] ord_mem [TABLE_DEPTH];

	logic [CW-1:0]      wr_idx;
	logic               wr_ok;
	logic [31:0]        x_rd_q, y_rd_q;
	logic signed [31:0] q_q;
	logic [31:0]        x_hi_q, y_hi_q;

	logic [32:0]        dx, dy;
	logic [34:0]        d2, d2_neg;
	logic [32:0]        dx_mag, dy_mag;
	logic [DY_W-1:0]    mdy_q;
	logic [D2_W-1:0]    md2_q;
	logic [DV_W-1:0]    dvs_q;
	logic               neg_q, zdx_q;

	logic [MUL_LO_W-1:0] mul_b;
	logic [PP_W-1:0]     pp;
	logic [PROD_W-1:0]   prod_q;

	logic [DV_W-1:0]     rem_q;
	logic [QUO_BITS-1:0] quo_q;
	logic                fits_q;
	logic [DV_W:0]       r2, r2_diff;
	logic                r2_ge;

	logic [SUM_W-1:0]    y_ext, quo_ext, sum;
	logic                sum_ovf;
	res_t                res_d;
	res_t                res_q;
	logic                res_valid_q;

	assign wr_idx = CW'(req.entry_index);
	assign wr_ok  = wr_idx < CW'(TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (cmd.mem_wr && wr_ok) begin
			abs_mem[wr_idx[AW-1:0]] <= req.entry_position;
			ord_mem[wr_idx[AW-1:0]] <= req.entry_value;
		end
		if (cmd.mem_rd) begin
			x_rd_q <= abs_mem[rd_addr];
			y_rd_q <= ord_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.query_ld) begin
			q_q <= req.query_position;
		end
		if (cmd.hi_ld) begin
			x_hi_q <= x_rd_q;
			y_hi_q <= y_rd_q;
		end
	end

	// segment differences; the low entry comes straight from the read register
	assign dx     = {x_hi_q[31], x_hi_q} - {x_rd_q[31], x_rd_q};
	assign dy     = {y_hi_q[31], y_hi_q} - {y_rd_q[31], y_rd_q};
	assign d2     = {{2{q_q[31]}}, q_q, 1'b0} - {{3{x_hi_q[31]}}, x_hi_q}
	                - {{3{x_rd_q[31]}}, x_rd_q};
	assign dx_mag = dx[32] ? (33'd0 - dx) : dx;
	assign dy_mag = dy[32] ? (33'd0 - dy) : dy;
	assign d2_neg = 35'd0 - d2;

	always_ff @(posedge clk) begin
		if (cmd.lo_ld) begin
			mdy_q <= dy_mag;
			md2_q <= d2[34] ? d2_neg[D2_W-1:0] : d2[D2_W-1:0];
			dvs_q <= {dx_mag, 1'b0};
			neg_q <= dy[32] ^ d2[34] ^ dx[32];
			zdx_q <= (dx == 33'd0);
		end
	end

	// two partial products through one 33 x 17 multiplier
	assign mul_b = cmd.mul_hi ? md2_q[D2_W-1:MUL_LO_W] : md2_q[MUL_LO_W-1:0];
	assign pp    = PP_W'(mdy_q) * PP_W'(mul_b);

	always_ff @(posedge clk) begin
		if (cmd.mul_lo) begin
			prod_q <= PROD_W'(pp);
		end else if (cmd.mul_hi) begin
			prod_q <= prod_q + {pp, {MUL_LO_W{1'b0}}};
		end
	end

	// restoring division, one quotient bit per step; quotient fits below
	// 2^QUO_BITS exactly when the upper dividend bits stay below the divisor
	assign r2      = {rem_q, quo_q[QUO_BITS-1]};
	assign r2_diff = r2 - {1'b0, dvs_q};
	assign r2_ge   = r2 >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			fits_q <= DV_W'(prod_q[PROD_W-1:QUO_BITS]) < dvs_q;
			rem_q  <= DV_W'(prod_q[PROD_W-1:QUO_BITS]);
			quo_q  <= prod_q[QUO_BITS-1:0];
		end else if (cmd.div_step) begin
			rem_q <= r2_ge ? r2_diff[DV_W-1:0] : r2[DV_W-1:0];
			quo_q <= {quo_q[QUO_BITS-2:0], r2_ge};
		end
	end

	assign y_ext   = {{(SUM_W-32){y_hi_q[31]}}, y_hi_q};
	assign quo_ext = {2'b00, quo_q};
	assign sum     = neg_q ? (y_ext - quo_ext) : (y_ext + quo_ext);
	assign sum_ovf = !((&sum[SUM_W-1:31]) || !(|sum[SUM_W-1:31]));

	always_comb begin
		res_d = '0;
		priority if (zdx_q) begin
			res_d.interpolated_value = y_hi_q;
			res_d.zero_width_segment = 1'b1;
		end else if (!fits_q) begin
			res_d.interpolated_value = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			res_d.saturated          = 1'b1;
		end else if (sum_ovf) begin
			res_d.interpolated_value = sum[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			res_d.saturated          = 1'b1;
		end else begin
			res_d.interpolated_value = sum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.res_ld) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign stat.x_lt_q   = $signed(x_rd_q) < q_q;
	assign stat.zero_dx  = zdx_q;
	assign stat.res_busy = res_valid_q && res_stall;
	assign res_valid     = res_valid_q;
	assign res           = res_q;

endmodule

`default_nettype wire

// ===== src/table_linear_interpolator.sv =====
// Piecewise-linear lookup over a table of TABLE_DEPTH breakpoints (signed Q11.20
// abscissa and ordinate). A load request writes one slot and is taken while the
// block stays idle, with no result; slots at or beyond TABLE_DEPTH are dropped. A
// query walks the table from slot 1 upward, with a read and a compare state per
// visited slot through the table's single read port, and stops at the first slot
// whose abscissa is not below the query or at slot point_count-2. It then reads
// the lower slot, forms the correction term with two 33 x 17 partial products and
// a 40-step restoring divider, and returns upper ordinate + slope * (query -
// segment midpoint), saturated to 32 bits. A zero-width segment skips the
// multiplier and divider and returns its upper ordinate. No new request is taken
// until the result is handed to the output register, which holds it while the
// output side stalls, and the next request can be taken in the cycle after that.
// point_count (APB offset 0, reset 2) is clamped to [2, TABLE_DEPTH]; write it
// only while the block is idle. Table contents are undefined until loaded.
`default_nettype none
`include "assert_macros.svh"

module table_linear_interpolator #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire tli_pkg::req_t req_data,
	output logic               res_valid,
	input  wire logic          res_stall,
	output tli_pkg::res_t      res_data
);
	import tli_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);

	logic [PC_W-1:0] point_count_q;
	dp_cmd_t         dp_cmd;
	dp_stat_t        dp_stat;
	logic [AW-1:0]   rd_addr;
	logic            req_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= PC_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_POINT_COUNT) begin
			point_count_q <= pwdata[PC_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_POINT_COUNT) ? 32'(point_count_q) : 32'd0;

	assign req_take = req_valid && !req_stall;

	tli_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_cmd    (req_data.cmd),
		.req_stall  (req_stall),
		.point_count(point_count_q),
		.stat       (dp_stat),
		.cmd        (dp_cmd),
		.rd_addr    (rd_addr)
	);

	tli_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_data),
		.cmd      (dp_cmd),
		.rd_addr  (rd_addr),
		.stat     (dp_stat),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res_data)
	);

	`TLI_ASSERT_NXT(a_query_blocks, clk, arst_n, req_take && req_data.cmd == CMD_QUERY, req_stall)
	`TLI_ASSERT_NXT(a_load_single_cycle, clk, arst_n, req_take && req_data.cmd == CMD_LOAD, !req_stall)
	`TLI_ASSERT_IMP(a_flags_exclusive, clk, arst_n, res_valid, !(res_data.zero_width_segment && res_data.saturated))
	`TLI_ASSERT_IMP(a_result_from_query, clk, arst_n, $rose(res_valid), $past(req_stall))

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import tli_pkg::*;

	localparam int unsigned DEPTH       = 64;
	localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 47 + 25;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam longint      S32_MAX      = 64'sd2147483647;
	localparam longint      S32_MIN      = -64'sd2147483648;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req_data  = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_t        res_data;

	// predictor state, updated at the edges where the block takes a request or a write
	logic signed [31:0] brk_x [DEPTH];
	logic signed [31:0] brk_y [DEPTH];
	logic [6:0]         point_count_reg = PC_RESET;
	res_t               interp_answers [$];

	// stimulus-side view of the table, used to aim queries
	logic signed [31:0] plan_x [DEPTH];
	bit                 plan_written [DEPTH];
	int unsigned        plan_n = 2;

	req_t        queued_reqs [$];
	bit          idle_on    = 1'b1;
	int unsigned send_wait  = 0;
	int unsigned take_wait  = 0;
	int unsigned cycle_count = 0;
	int unsigned errors     = 0;
	int unsigned n_loads    = 0;
	int unsigned n_queries  = 0;
	int unsigned n_zero     = 0;
	int unsigned n_clip     = 0;

	table_linear_interpolator #(.TABLE_DEPTH(DEPTH)) u_dut (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.req_valid, .req_stall, .req_data,
		.res_valid, .res_stall, .res_data
	);

	always #10 clk = ~clk;

	function automatic int unsigned draw_wait();
		return idle_on ? $urandom_range(0, 3) : 0;
	endfunction

	function automatic res_t interpolate_at(input logic signed [31:0] qpos);
		int unsigned n, i;
		longint q64, x_lo, x_hi, y_lo, y_hi, dx, dy, d2, qv, sum;
		logic [127:0] mag_dy, mag_d2, mag_dx, quo;
		logic neg;
		res_t r;
		n = point_count_reg;
		if (n < 2)
			n = 2;
		if (n > DEPTH)
			n = DEPTH;
		q64 = qpos;
		i = 1;
		while (brk_x[i] < qpos && i + 2 < n)
			i++;
		x_lo = brk_x[i-1];
		x_hi = brk_x[i];
		y_lo = brk_y[i-1];
		y_hi = brk_y[i];
		dx = x_hi - x_lo;
		r = '0;
		if (dx == 0) begin
			r.interpolated_value = y_hi[31:0];
			r.zero_width_segment = 1'b1;
			return r;
		end
		dy = y_hi - y_lo;
		d2 = 2 * q64 - x_hi - x_lo;
		neg = ((dy < 0) != (d2 < 0)) != (dx < 0);
		mag_dy = dy < 0 ? -dy : dy;
		mag_d2 = d2 < 0 ? -d2 : d2;
		mag_dx = dx < 0 ? -dx : dx;
		quo = (mag_dy * mag_d2) / (mag_dx << 1);
		// quotient too wide for the correction term: clip by sign
		if (quo[127:40] != '0) begin
			r.interpolated_value = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
			r.saturated = 1'b1;
			return r;
		end
		qv = quo[39:0];
		sum = y_hi + (neg ? -qv : qv);
		if (sum > S32_MAX) begin
			sum = S32_MAX;
			r.saturated = 1'b1;
		end else if (sum < S32_MIN) begin
			sum = S32_MIN;
			r.saturated = 1'b1;
		end
		r.interpolated_value = sum[31:0];
		return r;
	endfunction

	function automatic void apply_request(input req_t rq);
		res_t ans;
		if (rq.cmd == CMD_LOAD) begin
			brk_x[rq.entry_index] = rq.entry_position;
			brk_y[rq.entry_index] = rq.entry_value;
			n_loads++;
		end else begin
			ans = interpolate_at(rq.query_position);
			interp_answers.push_back(ans);
			n_queries++;
			n_zero += ans.zero_width_segment;
			n_clip += ans.saturated;
		end
	endfunction

	// request driver: wait the drawn gap, then present the next queued request
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				apply_request(req_data);
			if (!req_valid || !req_stall) begin
				if (send_wait != 0) begin
					send_wait <= send_wait - 1;
					req_valid <= 1'b0;
				end else if (queued_reqs.size() != 0) begin
					req_valid <= 1'b1;
					req_data  <= queued_reqs.pop_front();
					send_wait <= draw_wait();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare against the oldest predicted answer, then stall a while
	always @(posedge clk) begin : result_monitor
		res_t exp_r;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (interp_answers.size() == 0) begin
					$display("%0t: unexpected result value %h zero_width %b saturated %b",
						$time, res_data.interpolated_value, res_data.zero_width_segment,
						res_data.saturated);
					errors++;
				end else begin
					exp_r = interp_answers.pop_front();
					if (res_data.interpolated_value !== exp_r.interpolated_value) begin
						$display("%0t: interpolated_value expected %h, got %h", $time,
							exp_r.interpolated_value, res_data.interpolated_value);
						errors++;
					end
					if (res_data.zero_width_segment !== exp_r.zero_width_segment) begin
						$display("%0t: zero_width_segment expected %b, got %b", $time,
							exp_r.zero_width_segment, res_data.zero_width_segment);
						errors++;
					end
					if (res_data.saturated !== exp_r.saturated) begin
						$display("%0t: saturated expected %b, got %b", $time,
							exp_r.saturated, res_data.saturated);
						errors++;
					end
				end
				take_wait = draw_wait();
			end else if (take_wait != 0) begin
				take_wait--;
			end
			res_stall <= (take_wait != 0);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles, %0d answers outstanding", $time,
				CYCLE_LIMIT, interp_answers.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
			default: return $urandom();
		endcase
	endfunction

	task automatic push_load(input logic [5:0] idx, input logic [31:0] x,
			input logic [31:0] y);
		req_t rq;
		rq.cmd            = CMD_LOAD;
		rq.entry_index    = idx;
		rq.entry_position = x;
		rq.entry_value    = y;
		rq.query_position = $urandom();
		queued_reqs.push_back(rq);
		plan_x[idx]       = x;
		plan_written[idx] = 1'b1;
	endtask

	task automatic push_query(input logic [31:0] q);
		req_t rq;
		rq.cmd            = CMD_QUERY;
		rq.entry_index    = 6'($urandom_range(0, 63));
		rq.entry_position = $urandom();
		rq.entry_value    = $urandom();
		rq.query_position = q;
		queued_reqs.push_back(rq);
	endtask

	// ascending abscissae with random steps; a zero step makes a flat segment
	task automatic load_sorted_table(input int unsigned cnt);
		longint pos;
		int unsigned step_max;
		bit wide_y;
		pos = $signed(rand_word());
		pos = pos / 2;
		step_max = $urandom_range(0, 1) ? 32'h0001_0000 : 32'h0400_0000;
		wide_y = $urandom_range(0, 2) == 0;
		for (int k = 0; k < cnt; k++) begin
			if (k > 0 && $urandom_range(0, 9) != 0)
				pos += $urandom_range(1, step_max);
			if (pos > S32_MAX)
				pos = S32_MAX;
			push_load(6'(k), pos[31:0], wide_y ? rand_word() :
				32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000);
		end
	endtask

	task automatic random_item();
		longint lo, hi, q;
		if ($urandom_range(0, 3) == 0) begin
			push_load(6'($urandom_range(0, 63)), rand_word(), rand_word());
		end else begin
			case ($urandom_range(0, 3))
				0, 1: begin
					lo = plan_x[0];
					hi = plan_x[plan_n-1];
					if (lo > hi) begin
						q = lo;
						lo = hi;
						hi = q;
					end
					q = lo + $urandom_range(0, 32'(hi - lo));
				end
				2: begin
					q = plan_x[$urandom_range(0, plan_n - 1)];
					q = q + $urandom_range(0, 2) - 1;
				end
				default: q = $signed(rand_word());
			endcase
			push_query(q[31:0]);
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (queued_reqs.size() != 0 || req_valid || interp_answers.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_POINT_COUNT, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		point_count_reg = data[6:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned pc_plan [10];
		int unsigned need;
		bit reload;
		pc_plan = '{3, 64, 0, 127, 2, 17, 1, 64, 5, 9};
		pc_plan[5] = $urandom_range(2, 64);
		pc_plan[9] = $urandom_range(3, 12);
		for (int k = 0; k < DEPTH; k++) begin
			brk_x[k] = '0;
			brk_y[k] = '0;
			plan_x[k] = '0;
			plan_written[k] = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// two-point table at the reset point count
		push_load(6'd0, 32'h0000_0000, 32'h0000_0000);
		push_load(6'd1, 32'h0010_0000, 32'h0020_0000);
		push_query(32'h0008_0000);
		push_query(32'h8000_0000);
		push_query(32'h7FFF_FFFF);
		// flat segment
		push_load(6'd1, 32'h0000_0000, 32'h1234_5678);
		push_query(32'h0000_0000);
		push_query(32'h7FFF_FFFF);
		// full-range segment with falling ordinate
		push_load(6'd0, 32'h8000_0000, 32'h7FFF_FFFF);
		push_load(6'd1, 32'h7FFF_FFFF, 32'h8000_0000);
		push_query(32'h8000_0000);
		push_query(32'h7FFF_FFFF);
		push_query(32'h0000_0000);
		// steepest slope: correction term overflows both ways
		push_load(6'd0, 32'h0000_0000, 32'h8000_0000);
		push_load(6'd1, 32'h0000_0001, 32'h7FFF_FFFF);
		push_query(32'h7FFF_FFFF);
		push_query(32'h8000_0000);
		push_query(32'hFFFF_FFFF);
		// last slot, unused at this point count
		push_load(6'd63, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
		push_load(6'd0, 32'hFFFF_FFFF, 32'h5555_5555);
		push_query(32'h0000_0000);
		push_query(32'hFFFF_FFFF);

		foreach (pc_plan[p]) begin
			wait_drained();
			apb_write(32'(pc_plan[p]));
			plan_n = pc_plan[p] < 2 ? 2 : (pc_plan[p] > DEPTH ? DEPTH : pc_plan[p]);
			idle_on = (p % 3 != 2);
			need = plan_n > 2 ? plan_n - 2 : 1;
			reload = $urandom_range(0, 3) != 0;
			for (int k = 0; k <= need; k++)
				if (!plan_written[k])
					reload = 1'b1;
			if (reload)
				load_sorted_table(plan_n);
			repeat (20) random_item();
		end
		wait_drained();

		$display("Ran %0d loads and %0d queries over %0d point-count settings,",
			n_loads, n_queries, $size(pc_plan) + 1);
		$display("with %0d flat-segment answers and %0d clipped answers.", n_zero, n_clip);
		if (errors == 0 && interp_answers.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
